// File: rtl/core/lrle_pkg.sv
// ----------------------------------------------------------------------------
// lrle_pkg - shared types and constants for the run-length text encoder
// Holds the run symbol and sequencer state enums, the queue command record,
// ASCII codes, register indexes and small BCD helpers.
// ----------------------------------------------------------------------------
package lrle_pkg;

    // Largest supported grid side and the clamp applied to the size registers
    localparam int unsigned MAX_DIM = 4096;
    localparam int unsigned DIM_CAP_I = (MAX_DIM < 4096) ? MAX_DIM : 4096;
    localparam logic [12:0] DIM_CAP = 13'(DIM_CAP_I);

    // Configuration register indexes
    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LINE_LIMIT  = 2'd2;

    // Register reset values
    localparam logic [12:0] GRID_WIDTH_RST  = 13'd1;
    localparam logic [12:0] GRID_HEIGHT_RST = 13'd1;
    localparam logic [6:0]  LINE_LIMIT_RST  = 7'd70;

    // Output characters
    localparam logic [6:0] CHR_NL     = 7'd10;
    localparam logic [6:0] CHR_ZERO   = 7'h30;
    localparam logic [6:0] CHR_LIVE   = 7'h6F;   // 'o'
    localparam logic [6:0] CHR_DEAD   = 7'h62;   // 'b'
    localparam logic [6:0] CHR_DOLLAR = 7'h24;   // '$'
    localparam logic [6:0] CHR_BANG   = 7'h21;   // '!'

    // Line length saturation
    localparam logic [6:0] LINE_SAT = 7'd127;

    // Default queue depth (power of two)
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        SYM_NONE = 2'd0,
        SYM_DEAD = 2'd1,
        SYM_LIVE = 2'd2
    } t_sym;

    typedef enum logic [2:0] {
        BK_IDLE  = 3'd0,
        BK_A_NL  = 3'd1,
        BK_A_DIG = 3'd2,
        BK_A_SYM = 3'd3,
        BK_B_DIG = 3'd4,
        BK_B_SYM = 3'd5,
        BK_END   = 3'd6
    } t_bk_state;

    // One queue entry: everything a single cell makes the back end write.
    // Token A is the run closed by a symbol change (wrap checked), token B
    // the live run that closes a row (not wrap checked).
    typedef struct packed {
        logic        tok_a;
        logic [15:0] a_bcd;
        logic [2:0]  a_nd;     // digits to write, 0 when the count is one
        logic        a_live;
        logic        tok_b;
        logic [15:0] b_bcd;
        logic [2:0]  b_nd;
        logic        row_end;
        logic        bang;
    } t_cmd;

    // Increment a four digit BCD count
    function automatic logic [15:0] bcd_inc(input logic [15:0] v);
        logic [15:0] r;
        logic        c;
        r = v;
        c = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (c) begin
                if (v[i*4 +: 4] == 4'd9) begin
                    r[i*4 +: 4] = 4'd0;
                end else begin
                    r[i*4 +: 4] = v[i*4 +: 4] + 4'd1;
                    c = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // Digits written for a count: none when the count is one
    function automatic logic [2:0] bcd_ndig(input logic [15:0] v);
        logic [2:0] n;
        if (v == 16'h0001) begin
            n = 3'd0;
        end else if (v[15:12] != 4'd0) begin
            n = 3'd4;
        end else if (v[11:8] != 4'd0) begin
            n = 3'd3;
        end else if (v[7:4] != 4'd0) begin
            n = 3'd2;
        end else begin
            n = 3'd1;
        end
        return n;
    endfunction

    // Saturating line length add
    function automatic logic [6:0] line_add(input logic [6:0] ll, input logic [2:0] len);
        logic [7:0] s;
        s = {1'b0, ll} + {5'd0, len};
        return (s > {1'b0, LINE_SAT}) ? LINE_SAT : s[6:0];
    endfunction

endpackage

// File: rtl/core/lrle_front.sv
// ----------------------------------------------------------------------------
// lrle_front - cell intake and run tracking
// Accepts one cell per cycle unless the queue is full, follows column,
// row and open run; queues a command per cell that closes a run or a row.
// ----------------------------------------------------------------------------
module lrle_front
    import lrle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cell_valid,
    input  logic        i_cell_alive,
    output logic        o_cell_ready,
    input  logic [12:0] i_grid_width,
    input  logic [12:0] i_grid_height,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [11:0] r_col, n_col;
    logic [11:0] r_row, n_row;
    logic [15:0] r_bcd, n_bcd;
    t_sym        r_sym, n_sym;

    logic [12:0] w_clamp, h_clamp;
    logic        accept, same, row_end, last_row;
    t_sym        cur_sym;
    logic [15:0] run_bcd;

    // Clamp the size registers into range
    always_comb begin
        if (i_grid_width == 13'd0) begin
            w_clamp = 13'd1;
        end else if (i_grid_width > DIM_CAP) begin
            w_clamp = DIM_CAP;
        end else begin
            w_clamp = i_grid_width;
        end
        if (i_grid_height == 13'd0) begin
            h_clamp = 13'd1;
        end else if (i_grid_height > DIM_CAP) begin
            h_clamp = DIM_CAP;
        end else begin
            h_clamp = i_grid_height;
        end
    end

    assign o_cell_ready = !i_q_full;
    assign accept       = i_cell_valid && o_cell_ready;

    // Classify the cell against the open run and the row position
    always_comb begin
        cur_sym  = i_cell_alive ? SYM_LIVE : SYM_DEAD;
        same     = (r_sym == cur_sym);
        run_bcd  = same ? bcd_inc(r_bcd) : 16'h0001;
        row_end  = ({1'b0, r_col} + 13'd1) >= w_clamp;
        last_row = ({1'b0, r_row} + 13'd1) >= h_clamp;

        o_cmd.tok_a   = !same && (r_sym != SYM_NONE);
        o_cmd.a_bcd   = r_bcd;
        o_cmd.a_nd    = bcd_ndig(r_bcd);
        o_cmd.a_live  = (r_sym == SYM_LIVE);
        o_cmd.tok_b   = row_end && i_cell_alive;
        o_cmd.b_bcd   = run_bcd;
        o_cmd.b_nd    = bcd_ndig(run_bcd);
        o_cmd.row_end = row_end;
        o_cmd.bang    = last_row;

        o_push = accept && (o_cmd.tok_a || row_end);

        n_col = r_col;
        n_row = r_row;
        n_bcd = r_bcd;
        n_sym = r_sym;
        if (accept) begin
            if (row_end) begin
                n_col = 12'd0;
                n_bcd = 16'd0;
                n_sym = SYM_NONE;
                n_row = last_row ? 12'd0 : r_row + 12'd1;
            end else begin
                n_col = r_col + 12'd1;
                n_bcd = run_bcd;
                n_sym = cur_sym;
            end
        end
    end

    // Hold the position and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 12'd0;
            r_row <= 12'd0;
            r_bcd <= 16'd0;
            r_sym <= SYM_NONE;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_bcd <= n_bcd;
            r_sym <= n_sym;
        end
    end

endmodule

// File: rtl/core/lrle_queue.sv
// ----------------------------------------------------------------------------
// lrle_queue - command queue between intake and text writer
// Small first-in first-out register file of command records.
// ----------------------------------------------------------------------------
module lrle_queue
    import lrle_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_valid,
    output logic o_full
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_valid = (r_cnt != CW'(0));
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_cmd   = r_mem[r_rp];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// File: rtl/core/lrle_back.sv
// ----------------------------------------------------------------------------
// lrle_back - text writer
// Takes queued commands and writes their characters one per cycle into an
// output register when free, tracking text line length and wrapping tokens.
// ----------------------------------------------------------------------------
module lrle_back
    import lrle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_valid,
    output logic       o_pop,
    input  logic [6:0] i_line_limit,
    output logic       o_valid,
    output logic [6:0] o_char,
    output logic       o_last,
    input  logic       i_ready
);

    t_bk_state  r_state, n_state;
    logic [1:0] r_dig, n_dig;
    logic [6:0] r_ll, n_ll;
    t_cmd       r_cur, n_cur;
    logic       r_out_valid;
    logic [6:0] r_out_char;
    logic       r_out_last;

    t_bk_state  e_state;
    logic [1:0] e_dig;
    logic [6:0] e_ll;
    logic [6:0] ch;
    logic       done, fire, slot_free, load, wrap;
    logic [2:0] len_a, len_b, ld_len_a;
    logic [3:0] a_digit, b_digit;

    assign slot_free = !r_out_valid || i_ready;
    assign fire      = (r_state != BK_IDLE) && slot_free;
    assign len_a     = r_cur.a_nd + 3'd1;
    assign len_b     = r_cur.b_nd + 3'd1;
    assign ld_len_a  = i_cmd.a_nd + 3'd1;
    assign a_digit   = r_cur.a_bcd[{r_dig, 2'b00} +: 4];
    assign b_digit   = r_cur.b_bcd[{r_dig, 2'b00} +: 4];

    // Sequence the characters of the current command and pick up the next
    always_comb begin
        e_state = r_state;
        e_dig   = r_dig;
        e_ll    = r_ll;
        ch      = CHR_NL;
        done    = 1'b0;
        case (r_state)
            BK_A_NL: begin
                ch   = CHR_NL;
                e_ll = 7'd0;
                if (r_cur.a_nd != 3'd0) begin
                    e_state = BK_A_DIG;
                    e_dig   = 2'(r_cur.a_nd - 3'd1);
                end else begin
                    e_state = BK_A_SYM;
                end
            end
            BK_A_DIG: begin
                ch = CHR_ZERO + {3'd0, a_digit};
                if (r_dig == 2'd0) begin
                    e_state = BK_A_SYM;
                end else begin
                    e_dig = r_dig - 2'd1;
                end
            end
            BK_A_SYM: begin
                ch   = r_cur.a_live ? CHR_LIVE : CHR_DEAD;
                e_ll = line_add(r_ll, len_a);
                if (!r_cur.row_end) begin
                    done = 1'b1;
                end else if (r_cur.tok_b) begin
                    if (r_cur.b_nd != 3'd0) begin
                        e_state = BK_B_DIG;
                        e_dig   = 2'(r_cur.b_nd - 3'd1);
                    end else begin
                        e_state = BK_B_SYM;
                    end
                end else begin
                    e_state = BK_END;
                end
            end
            BK_B_DIG: begin
                ch = CHR_ZERO + {3'd0, b_digit};
                if (r_dig == 2'd0) begin
                    e_state = BK_B_SYM;
                end else begin
                    e_dig = r_dig - 2'd1;
                end
            end
            BK_B_SYM: begin
                ch      = CHR_LIVE;
                e_ll    = line_add(r_ll, len_b);
                e_state = BK_END;
            end
            BK_END: begin
                ch   = r_cur.bang ? CHR_BANG : CHR_DOLLAR;
                e_ll = r_cur.bang ? 7'd0 : line_add(r_ll, 3'd1);
                done = 1'b1;
            end
            default: begin
                e_state = r_state;
            end
        endcase

        n_state = r_state;
        n_dig   = r_dig;
        n_ll    = r_ll;
        n_cur   = r_cur;
        if (fire) begin
            n_state = done ? BK_IDLE : e_state;
            n_dig   = e_dig;
            n_ll    = e_ll;
        end

        // Load the next command, wrap checked against the updated line length
        load  = i_cmd_valid && ((r_state == BK_IDLE) || (fire && done));
        o_pop = load;
        wrap  = ({1'b0, n_ll} + {5'd0, ld_len_a}) > {1'b0, i_line_limit};
        if (load) begin
            n_cur = i_cmd;
            if (i_cmd.tok_a) begin
                if (wrap) begin
                    n_state = BK_A_NL;
                end else if (i_cmd.a_nd != 3'd0) begin
                    n_state = BK_A_DIG;
                    n_dig   = 2'(i_cmd.a_nd - 3'd1);
                end else begin
                    n_state = BK_A_SYM;
                end
            end else if (i_cmd.tok_b) begin
                if (i_cmd.b_nd != 3'd0) begin
                    n_state = BK_B_DIG;
                    n_dig   = 2'(i_cmd.b_nd - 3'd1);
                end else begin
                    n_state = BK_B_SYM;
                end
            end else begin
                n_state = BK_END;
            end
        end
    end

    // Hold sequencer state and line length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_dig   <= 2'd0;
            r_ll    <= 7'd0;
        end else begin
            r_state <= n_state;
            r_dig   <= n_dig;
            r_ll    <= n_ll;
        end
    end

    // Hold the command being written
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    // Output register: refill whenever empty or taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            r_out_char <= ch;
            r_out_last <= done;
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

endmodule

// File: rtl/core/life_rle_pattern_encoder.sv
// ----------------------------------------------------------------------------
// life_rle_pattern_encoder - run-length text encoder for cell grids
//
//   channel    direction  signals                              per transaction
//   s_axis     in         tvalid/tready/tdata[7:0]             one cell
//   m_axis     out        tvalid/tready/tdata[7:0]/tlast       one character
//   cfg        in         valid/ready/index[1:0]/data[12:0]    one register
//
// Cells are taken one per cycle while the command queue has room; a cell
// that closes a run or a row queues one command. The writer sends one
// character per cycle while the output is taken, and the queue
// (QUEUE_DEPTH commands) absorbs bursts and input stalls when it fills.
// Synchronous active-low reset clears position, run, line length and queue.
// ----------------------------------------------------------------------------
module life_rle_pattern_encoder
    import lrle_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] cell_alive, [7:1] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic        o_m_axis_tlast,   // last_of_item
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    logic [12:0] r_grid_width;
    logic [12:0] r_grid_height;
    logic [6:0]  r_line_limit;

    t_cmd        f_cmd, q_cmd;
    logic        f_push, q_valid, q_full, b_pop;
    logic [6:0]  b_char;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
            r_line_limit  <= LINE_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                CFG_LINE_LIMIT:  r_line_limit  <= i_cfg_data[6:0];
                default: begin
                    r_line_limit <= r_line_limit;
                end
            endcase
        end
    end

    lrle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cell_valid  (i_s_axis_tvalid),
        .i_cell_alive  (i_s_axis_tdata[0]),
        .o_cell_ready  (o_s_axis_tready),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .i_q_full      (q_full),
        .o_push        (f_push),
        .o_cmd         (f_cmd)
    );

    lrle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .i_pop   (b_pop),
        .o_cmd   (q_cmd),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    lrle_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (q_cmd),
        .i_cmd_valid  (q_valid),
        .o_pop        (b_pop),
        .i_line_limit (r_line_limit),
        .o_valid      (o_m_axis_tvalid),
        .o_char       (b_char),
        .o_last       (o_m_axis_tlast),
        .i_ready      (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {1'b0, b_char};

endmodule
